FILE: rtl/framed_conv_encoder_scrambler_assert.svh
// -----------------------------------------------------------------------------
// Assertion macros for the framed convolutional encoder and scrambler.
// Each macro uses clk and rst_n of the module it stands in.
// -----------------------------------------------------------------------------
`ifndef FRAMED_CONV_ENCODER_SCRAMBLER_ASSERT_SVH
`define FRAMED_CONV_ENCODER_SCRAMBLER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define FCES_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fces assertion failed");

// Next-cycle implication
`define FCES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fces assertion failed");

`else

`define FCES_ASSERT_SAME(lbl, ante, cons)
`define FCES_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/fces_pkg.sv
// -----------------------------------------------------------------------------
// fces_pkg
// Types, constants and bit-level functions shared by the encoder modules.
// -----------------------------------------------------------------------------
package fces_pkg;

  localparam int FRAME_PAIRS_W = 15;
  localparam int SYNC_WORD_W   = 32;
  localparam int BIT_POS_W     = 16;
  localparam int HIST_W        = 6;
  localparam int SCR_W         = 8;
  localparam int NIB_W         = 4;
  localparam int SYNC_CNT_W    = 3;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [FRAME_PAIRS_W-1:0] FRAME_PAIRS_RST = 15'd500;
  localparam logic [SYNC_WORD_W-1:0]   SYNC_WORD_RST   = 32'h1ACF_FC1D;
  localparam logic [SCR_W-1:0]         SCR_SEED        = 8'hFF;
  localparam logic [SYNC_CNT_W-1:0]    SYNC_CNT_LAST   = 3'd7;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_FRAME_PAIRS = 1'b0,
    REG_SYNC_WORD   = 1'b1
  } reg_idx_t;

  // Configuration handed from the register block to the datapath
  typedef struct packed {
    logic [FRAME_PAIRS_W-1:0] frame_pairs;
    logic [SYNC_WORD_W-1:0]   sync_word;
  } cfg_t;

  typedef struct packed {
    logic [SCR_W-1:0] state;
    logic [NIB_W-1:0] nib;
  } scr_res_t;

  // K=7 encoder, generators 171/133 octal; returns {g1, g2}
  function automatic logic [1:0] conv_code(input logic [HIST_W-1:0] h, input logic b);
    logic g1;
    logic g2;
    g1 = h[0] ^ h[3] ^ h[4] ^ h[5] ^ b;
    g2 = h[0] ^ h[1] ^ h[3] ^ h[4] ^ b;
    return {g1, g2};
  endfunction

  // Scramble a nibble MSB first, one LFSR step per bit
  function automatic scr_res_t scramble_nibble(input logic [SCR_W-1:0] seed,
                                               input logic [NIB_W-1:0] nib);
    scr_res_t   res;
    logic [SCR_W-1:0] s;
    logic       fb;
    s = seed;
    res.nib = '0;
    for (int k = NIB_W - 1; k >= 0; k--) begin
      res.nib[k] = nib[k] ^ s[0];
      fb = s[0] ^ s[3] ^ s[5] ^ s[7];
      s = {fb, s[SCR_W-1:1]};
    end
    res.state = s;
    return res;
  endfunction

endpackage

FILE: rtl/fces_regs.sv
// -----------------------------------------------------------------------------
// fces_regs
// APB-style configuration registers: frame length and sync word.
// -----------------------------------------------------------------------------
module fces_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [fces_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [fces_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [fces_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready,
  output fces_pkg::cfg_t                    cfg
);
  import fces_pkg::*;

  logic [FRAME_PAIRS_W-1:0] frame_pairs_r;
  logic [SYNC_WORD_W-1:0]   sync_word_r;
  logic                     wr_en;
  reg_idx_t                 idx;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_pairs_r <= FRAME_PAIRS_RST;
      sync_word_r   <= SYNC_WORD_RST;
    end else if (wr_en) begin
      case (idx)
        REG_FRAME_PAIRS: frame_pairs_r <= cfg_pwdata[FRAME_PAIRS_W-1:0];
        REG_SYNC_WORD:   sync_word_r   <= cfg_pwdata[SYNC_WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_FRAME_PAIRS: cfg_prdata = {{(CFG_DATA_W-FRAME_PAIRS_W){1'b0}}, frame_pairs_r};
      REG_SYNC_WORD:   cfg_prdata = sync_word_r;
      default:         cfg_prdata = '0;
    endcase
  end

  assign cfg.frame_pairs = frame_pairs_r;
  assign cfg.sync_word   = sync_word_r;

endmodule

FILE: rtl/fces_core.sv
// -----------------------------------------------------------------------------
// fces_core
// Input register, sync sequencer, encoder, scrambler and result register.
// -----------------------------------------------------------------------------
`include "framed_conv_encoder_scrambler_assert.svh"

module fces_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fces_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_bit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fces_pkg::NIB_W-1:0]    out_nib,
  output logic                          out_is_sync,
  output logic                          out_frame_end,
  output logic                          out_last
);
  import fces_pkg::*;

  // Input register
  logic                    item_valid_r;
  logic                    item_bit_r;
  // Frame and coder state
  logic [SYNC_CNT_W-1:0]   sync_cnt_r;
  logic [BIT_POS_W-1:0]    bitpos_r;
  logic [HIST_W-1:0]       hist_r;
  logic [SCR_W-1:0]        scr_r;
  logic [1:0]              held_r;
  // Result register
  logic                    out_valid_r;
  logic [NIB_W-1:0]        out_nib_r;
  logic                    out_sync_r;
  logic                    out_fend_r;
  logic                    out_last_r;

  logic                    frame_start;
  logic                    sync_last;
  logic [4:0]              sync_sel;
  logic [NIB_W-1:0]        sync_nib;
  logic [HIST_W-1:0]       hist_use;
  logic [1:0]              coded;
  logic [NIB_W-1:0]        data_nib;
  logic [SCR_W-1:0]        scr_in;
  logic [NIB_W-1:0]        nib_in;
  scr_res_t                scr_out;
  logic [FRAME_PAIRS_W-1:0] pairs;
  logic [BIT_POS_W:0]      limit;
  logic [BIT_POS_W:0]      pos_inc;
  logic                    fend;
  logic                    emit;
  logic                    out_ok;
  logic                    step;
  logic                    consume;

  assign frame_start = (bitpos_r == '0);
  assign sync_last   = (sync_cnt_r == SYNC_CNT_LAST);

  // Sync nibble select, most significant nibble first
  assign sync_sel = {~sync_cnt_r, 2'b00};
  assign sync_nib = cfg.sync_word[sync_sel +: NIB_W];

  // Encoder; history is cleared at frame start
  assign hist_use = frame_start ? '0 : hist_r;
  assign coded    = conv_code(hist_use, item_bit_r);
  assign data_nib = {held_r, coded};

  // Scrambler, reloaded on the first sync nibble
  assign scr_in  = frame_start ? ((sync_cnt_r == '0) ? SCR_SEED : scr_r) : scr_r;
  assign nib_in  = frame_start ? sync_nib : data_nib;
  assign scr_out = scramble_nibble(scr_in, nib_in);

  // Frame end test; zero length counts as one pair
  assign pairs   = (cfg.frame_pairs == '0) ? FRAME_PAIRS_W'(1) : cfg.frame_pairs;
  assign limit   = {1'b0, pairs, 1'b0};
  assign pos_inc = {1'b0, bitpos_r} + (BIT_POS_W+1)'(1);
  assign fend    = (pos_inc >= limit);

  // Handshake control
  assign emit     = item_valid_r & (frame_start | bitpos_r[0]);
  assign out_ok   = ~out_valid_r | out_ready;
  assign step     = item_valid_r & (~emit | out_ok);
  assign consume  = step & (~frame_start | sync_last);
  assign in_ready = ~item_valid_r | consume;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid_r <= 1'b1;
    end else if (consume) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_bit_r <= in_bit;
    end
  end

  // Frame, coder and scrambler state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_cnt_r <= '0;
      bitpos_r   <= '0;
      hist_r     <= '0;
      scr_r      <= SCR_SEED;
      held_r     <= '0;
    end else if (step) begin
      if (emit) begin
        scr_r <= scr_out.state;
      end
      if (consume) begin
        sync_cnt_r <= '0;
        hist_r     <= {item_bit_r, hist_use[HIST_W-1:1]};
        if (!bitpos_r[0]) begin
          held_r   <= coded;
          bitpos_r <= pos_inc[BIT_POS_W-1:0];
        end else begin
          held_r   <= '0;
          bitpos_r <= fend ? '0 : pos_inc[BIT_POS_W-1:0];
        end
      end else begin
        sync_cnt_r <= sync_cnt_r + SYNC_CNT_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_nib_r  <= scr_out.nib;
      out_sync_r <= frame_start;
      out_fend_r <= ~frame_start & fend;
      out_last_r <= ~frame_start | sync_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_nib       = out_nib_r;
  assign out_is_sync   = out_sync_r;
  assign out_frame_end = out_fend_r;
  assign out_last      = out_last_r;

  // Sync nibbles never close a frame
  `FCES_ASSERT_SAME(a_sync_no_fend, out_valid_r && out_sync_r, !out_fend_r)
  // A frame end is always the last result of its transaction
  `FCES_ASSERT_SAME(a_fend_last, out_valid_r && out_fend_r, out_last_r)
  // Sync sequencer steps by one per emitted sync nibble
  `FCES_ASSERT_NEXT(a_sync_step, step && frame_start && !sync_last,
                    sync_cnt_r == $past(sync_cnt_r) + SYNC_CNT_W'(1))
  // Second bit of a pair always yields one data nibble
  `FCES_ASSERT_NEXT(a_pair_out, step && bitpos_r[0],
                    out_valid_r && !out_sync_r && out_last_r)

endmodule

FILE: rtl/framed_conv_encoder_scrambler.sv
// -----------------------------------------------------------------------------
// framed_conv_encoder_scrambler
// Framed K=7 rate-1/2 convolutional encoder with scrambled sync marker.
// -----------------------------------------------------------------------------
//  channel  | direction | contents
//  ---------+-----------+------------------------------------------------------
//  in_*     | slave     | tdata[0] = data_bit
//  out_*    | master    | tdata[3:0] = nibble, tuser = {frame_end, is_sync}, tlast = last
//  cfg_*    | APB slave | 0x0 frame_pairs[14:0], 0x4 sync_word[31:0]
//
// One data bit is taken per cycle outside the sync marker unless a stalled result
// channel holds a nibble; the second bit of each pair yields one nibble through the result register.
// The first bit of a frame holds the input register while the sync sequencer
// emits the eight sync nibbles, one per cycle unless the result channel stalls.
// rst_n is synchronous; after reset the next bit starts a new frame.
// A stalled result channel blocks only when a nibble must be emitted.
// -----------------------------------------------------------------------------
module framed_conv_encoder_scrambler (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [0] data_bit, [7:1] zero
  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [3:0] nibble, [7:4] zero
  output logic [1:0]                      out_tuser,  // [0] is_sync, [1] frame_end
  output logic                            out_tlast,
  // Configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [fces_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [fces_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [fces_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import fces_pkg::*;

  cfg_t             cfg;
  logic [NIB_W-1:0] nib;
  logic             is_sync;
  logic             frame_end;

  fces_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  fces_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_bit        (in_tdata[0]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_nib       (nib),
    .out_is_sync   (is_sync),
    .out_frame_end (frame_end),
    .out_last      (out_tlast)
  );

  // Pack result fields
  assign out_tdata = {{(8-NIB_W){1'b0}}, nib};
  assign out_tuser = {frame_end, is_sync};

endmodule
